[src/isolated_pixel_despeckle_glyph_map_macros.svh]
// assertion macros shared by the despeckle block
`ifndef ISOLATED_PIXEL_DESPECKLE_GLYPH_MAP_MACROS_SVH
`define ISOLATED_PIXEL_DESPECKLE_GLYPH_MAP_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition implies consequence in the same cycle
`define IDPG_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// condition implies consequence in the next cycle
`define IDPG_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define IDPG_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define IDPG_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[src/idpg_pkg.sv]
`default_nettype none

package idpg_pkg;

    localparam int LEVEL_W    = 4;
    localparam int GLYPH_W    = 7;
    localparam int ROW_W      = 12;
    localparam int COLS_CFG_W = 7;
    localparam int SLOT_W     = 2;
    localparam int SUM_W      = 6;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [ROW_W-1:0]      ROWS_RESET = 12'd20;
    localparam logic [COLS_CFG_W-1:0] COLS_RESET = 7'd30;
    localparam logic [LEVEL_W-1:0]    LEVEL_MAX  = 4'd9;
    localparam logic [LEVEL_W-1:0]    NEAR_LIMIT = 4'd1;

    // register index codes (byte address bit 2)
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    // per-item job flags handed from front to back
    typedef struct packed {
        logic has_a;     // emit pixel one row up
        logic has_b;     // last row: emit pixel to the left
        logic has_c;     // last row, last column: emit this pixel
        logic prev_row;  // a row above exists
        logic up2;       // two rows above exist
        logic right_ok;  // column to the right exists
        logic left1;     // one column to the left exists
        logic left2;     // two columns to the left exist
        logic row_end;   // this column closes the row
    } job_flags_t;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        return (s == 2'd2) ? 2'd0 : s + 2'd1;
    endfunction

    function automatic logic [SLOT_W-1:0] prev_slot(input logic [SLOT_W-1:0] s);
        return (s == 2'd0) ? 2'd2 : s - 2'd1;
    endfunction

    // ten-level character ramp " .':~*=?%#"
    function automatic logic [GLYPH_W-1:0] ramp_glyph(input logic [LEVEL_W-1:0] lvl);
        logic [GLYPH_W-1:0] g;
        case (lvl)
            4'd0:    g = 7'd32;
            4'd1:    g = 7'd46;
            4'd2:    g = 7'd39;
            4'd3:    g = 7'd58;
            4'd4:    g = 7'd126;
            4'd5:    g = 7'd42;
            4'd6:    g = 7'd61;
            4'd7:    g = 7'd63;
            4'd8:    g = 7'd37;
            default: g = 7'd35;
        endcase
        return g;
    endfunction

    function automatic logic near(input logic [LEVEL_W-1:0] a, input logic [LEVEL_W-1:0] b);
        logic [LEVEL_W-1:0] d;
        d = (a > b) ? a - b : b - a;
        return d <= NEAR_LIMIT;
    endfunction

    // impulse test and rounded neighbor mean, then glyph lookup
    function automatic logic [GLYPH_W-1:0] filter_glyph(
        input logic [LEVEL_W-1:0] v,
        input logic [LEVEL_W-1:0] up,  input logic up_ok,
        input logic [LEVEL_W-1:0] rt,  input logic rt_ok,
        input logic [LEVEL_W-1:0] dn,  input logic dn_ok,
        input logic [LEVEL_W-1:0] lf,  input logic lf_ok
    );
        logic [SUM_W-1:0]   sum;
        logic [2:0]         cnt;
        logic               close;
        logic [SUM_W:0]     dbl;
        logic [SUM_W+10:0]  prod;
        logic [SUM_W-1:0]   mean;
        logic [LEVEL_W-1:0] lvl;
        sum   = '0;
        cnt   = '0;
        close = 1'b0;
        dbl   = '0;
        prod  = '0;
        if (up_ok) begin
            sum = sum + SUM_W'(up); cnt = cnt + 3'd1; close = close | near(v, up);
        end
        if (rt_ok) begin
            sum = sum + SUM_W'(rt); cnt = cnt + 3'd1; close = close | near(v, rt);
        end
        if (dn_ok) begin
            sum = sum + SUM_W'(dn); cnt = cnt + 3'd1; close = close | near(v, dn);
        end
        if (lf_ok) begin
            sum = sum + SUM_W'(lf); cnt = cnt + 3'd1; close = close | near(v, lf);
        end
        // (2*sum + n) / (2*n); divide by six through 171/1024
        case (cnt)
            3'd1: mean = sum;
            3'd2: mean = SUM_W'((SUM_W+1)'(sum) + 7'd1 >> 1);
            3'd3: begin
                dbl  = {sum, 1'b0} + 7'd3;
                prod = (SUM_W+11)'(dbl) * 17'd171;
                mean = SUM_W'(prod >> 10);
            end
            3'd4: mean = SUM_W'((SUM_W+1)'(sum) + 7'd2 >> 2);
            default: mean = SUM_W'(v);
        endcase
        if (cnt == 3'd0 || close) begin
            lvl = v;
        end else if (mean > SUM_W'(LEVEL_MAX)) begin
            lvl = LEVEL_MAX;
        end else begin
            lvl = LEVEL_W'(mean);
        end
        if (lvl > LEVEL_MAX) begin
            lvl = LEVEL_MAX;
        end
        return ramp_glyph(lvl);
    endfunction

endpackage

`default_nettype wire

[src/idpg_queue.sv]
`default_nettype none
`include "isolated_pixel_despeckle_glyph_map_macros.svh"

module idpg_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   full,
    input  wire logic              pop,
    output logic [DATA_W-1:0]      head_data,
    output logic                   not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head_data = slot_reg[rd_ptr_reg];

    // pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    `IDPG_ASSERT_IMPLIES(a_no_overflow, aclk, aresetn, push, !full)
    `IDPG_ASSERT_IMPLIES(a_no_underflow, aclk, aresetn, pop, not_empty)

endmodule

`default_nettype wire

[src/idpg_front.sv]
`default_nettype none

module idpg_front #(
    parameter int MAX_COLUMNS = 64,
    parameter int COL_W       = 6
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [idpg_pkg::LEVEL_W-1:0]        s_pixel_level,
    input  wire logic [idpg_pkg::ROW_W-1:0]          rows_cfg,
    input  wire logic [idpg_pkg::COLS_CFG_W-1:0]     cols_cfg,
    input  wire logic                                q_full,
    output logic                                     push,
    output logic [idpg_pkg::LEVEL_W-1:0]             job_level,
    output logic [COL_W-1:0]                         job_col,
    output logic [idpg_pkg::SLOT_W-1:0]              job_slot,
    output idpg_pkg::job_flags_t                     job_flags
);
    import idpg_pkg::*;

    localparam int CNT_W = COL_W + 1;

    logic [COL_W-1:0]  col_cnt_reg, col_cnt_next;
    logic [ROW_W-1:0]  row_cnt_reg, row_cnt_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    logic [ROW_W-1:0]  rows_eff;
    logic [31:0]       cols_wide;
    logic [CNT_W-1:0]  cols_eff;
    logic              wrap_pre;
    logic [ROW_W-1:0]  row_a;
    logic [SLOT_W-1:0] slot_a;
    logic [ROW_W-1:0]  r;
    logic [SLOT_W-1:0] s;
    logic [COL_W-1:0]  c;
    logic [CNT_W-1:0]  c_plus;
    logic [ROW_W:0]    r_plus;
    logic              last_row;
    logic              row_done;

    assign s_ready = !q_full;
    assign push    = s_valid && !q_full;

    // effective frame size: zero means one, columns capped at the line store
    always_comb begin
        rows_eff  = (rows_cfg == '0) ? ROW_W'(1) : rows_cfg;
        cols_wide = {{(32-COLS_CFG_W){1'b0}}, cols_cfg};
        if (cols_wide == 32'd0) begin
            cols_wide = 32'd1;
        end else if (cols_wide > 32'(MAX_COLUMNS)) begin
            cols_wide = 32'(MAX_COLUMNS);
        end
        cols_eff = CNT_W'(cols_wide);
    end

    // position of this item, wrapping counters left beyond a shrunk size
    always_comb begin
        wrap_pre = {1'b0, col_cnt_reg} >= cols_eff;
        c        = wrap_pre ? '0 : col_cnt_reg;
        row_a    = wrap_pre ? row_cnt_reg + ROW_W'(1) : row_cnt_reg;
        slot_a   = wrap_pre ? next_slot(slot_reg) : slot_reg;
        if (row_a >= rows_eff) begin
            r = '0;
            s = '0;
        end else begin
            r = row_a;
            s = slot_a;
        end
        c_plus   = {1'b0, c} + CNT_W'(1);
        r_plus   = {1'b0, r} + (ROW_W+1)'(1);
        last_row = (r_plus == {1'b0, rows_eff});
        row_done = (c_plus >= cols_eff);
    end

    // classify the item
    always_comb begin
        job_level          = (s_pixel_level > LEVEL_MAX) ? LEVEL_MAX : s_pixel_level;
        job_col            = c;
        job_slot           = s;
        job_flags.has_a    = (r != '0);
        job_flags.has_b    = last_row && (c != '0);
        job_flags.has_c    = last_row && row_done;
        job_flags.prev_row = (r != '0);
        job_flags.up2      = (r > ROW_W'(1));
        job_flags.right_ok = !row_done;
        job_flags.left1    = (c != '0);
        job_flags.left2    = (c > COL_W'(1));
        job_flags.row_end  = row_done;
    end

    // counters after the item
    always_comb begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        slot_next    = slot_reg;
        if (push) begin
            if (row_done) begin
                col_cnt_next = '0;
                if (r_plus >= {1'b0, rows_eff}) begin
                    row_cnt_next = '0;
                    slot_next    = '0;
                end else begin
                    row_cnt_next = ROW_W'(r_plus);
                    slot_next    = next_slot(s);
                end
            end else begin
                col_cnt_next = COL_W'(c_plus);
                row_cnt_next = r;
                slot_next    = s;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            slot_reg    <= '0;
        end else begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
            slot_reg    <= slot_next;
        end
    end

endmodule

`default_nettype wire

[src/idpg_back.sv]
`default_nettype none
`include "isolated_pixel_despeckle_glyph_map_macros.svh"

module idpg_back #(
    parameter int MAX_COLUMNS = 64,
    parameter int COL_W       = 6
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          q_valid,
    output logic                               q_pop,
    input  wire logic [idpg_pkg::LEVEL_W-1:0]  q_level,
    input  wire logic [COL_W-1:0]              q_col,
    input  wire logic [idpg_pkg::SLOT_W-1:0]   q_slot,
    input  wire idpg_pkg::job_flags_t          q_flags,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [idpg_pkg::GLYPH_W-1:0]       m_glyph,
    output logic                               m_row_end,
    output logic                               m_frame_end,
    output logic                               m_run_last
);
    import idpg_pkg::*;

    localparam int DEPTH  = 3 * MAX_COLUMNS;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD0  = 3'd1;
    localparam logic [2:0] ST_RD1  = 3'd2;
    localparam logic [2:0] ST_RD2  = 3'd3;
    localparam logic [2:0] ST_RD3  = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    localparam int P_A = 0;
    localparam int P_B = 1;
    localparam int P_C = 2;

    logic [LEVEL_W-1:0] mem [DEPTH];

    logic [2:0]         state_reg, state_next;
    logic [2:0]         pend_reg, pend_next;
    job_flags_t         flags_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [COL_W-1:0]   col_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [LEVEL_W-1:0] rd0_reg, rd1_reg;
    logic [LEVEL_W-1:0] up_a_reg, ctr_a_reg, right_a_reg, left_a_reg;
    logic [LEVEL_W-1:0] ctr_b_reg, left_b_reg;
    logic               m_valid_reg;
    logic [GLYPH_W-1:0] m_glyph_reg;
    logic               m_row_end_reg, m_frame_end_reg, m_run_last_reg;

    logic [SLOT_W-1:0]  s1, s2;
    logic [ADDR_W-1:0]  waddr, raddr0, raddr1;
    logic               mem_we;
    logic [2:0]         sel;
    logic               out_free, out_load;
    logic [GLYPH_W-1:0] out_glyph;
    logic               out_row_end, out_frame_end, out_run_last;

    // line store address: slot times row length plus column
    function automatic logic [ADDR_W-1:0] store_addr(input logic [SLOT_W-1:0] sl,
                                                     input logic [COL_W-1:0] cl);
        int unsigned wide;
        wide = 32'(sl) * 32'(MAX_COLUMNS) + 32'(cl);
        return (wide >= 32'(DEPTH)) ? '0 : ADDR_W'(wide);
    endfunction

    assign m_valid     = m_valid_reg;
    assign m_glyph     = m_glyph_reg;
    assign m_row_end   = m_row_end_reg;
    assign m_frame_end = m_frame_end_reg;
    assign m_run_last  = m_run_last_reg;

    assign q_pop  = (state_reg == ST_IDLE) && q_valid;
    assign mem_we = q_pop;
    assign waddr  = store_addr(q_slot, q_col);
    assign s1     = prev_slot(slot_reg);
    assign s2     = prev_slot(s1);

    // read pairs: rows above, then row above left/right, then this row to the left
    always_comb begin
        raddr0 = '0;
        raddr1 = '0;
        case (state_reg)
            ST_RD0: begin
                raddr0 = store_addr(s2, col_reg);
                raddr1 = store_addr(s1, col_reg);
            end
            ST_RD1: begin
                raddr0 = store_addr(s1, col_reg + COL_W'(1));
                raddr1 = store_addr(s1, col_reg - COL_W'(1));
            end
            ST_RD2: begin
                raddr0 = store_addr(slot_reg, col_reg - COL_W'(1));
                raddr1 = store_addr(slot_reg, col_reg - COL_W'(2));
            end
            default: begin
                raddr0 = '0;
                raddr1 = '0;
            end
        endcase
    end

    // line store
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[waddr] <= q_level;
        end
        rd0_reg <= mem[raddr0];
        rd1_reg <= mem[raddr1];
    end

    // oldest pending result first
    always_comb begin
        sel[P_A] = pend_reg[P_A];
        sel[P_B] = pend_reg[P_B] && !pend_reg[P_A];
        sel[P_C] = pend_reg[P_C] && !pend_reg[P_B] && !pend_reg[P_A];
    end

    // shared filter with neighbors picked per result
    always_comb begin
        if (sel[P_A]) begin
            out_glyph     = filter_glyph(ctr_a_reg,
                                         up_a_reg, flags_reg.up2,
                                         right_a_reg, flags_reg.right_ok,
                                         level_reg, 1'b1,
                                         left_a_reg, flags_reg.left1);
            out_row_end   = flags_reg.row_end;
            out_frame_end = 1'b0;
        end else if (sel[P_B]) begin
            out_glyph     = filter_glyph(ctr_b_reg,
                                         left_a_reg, flags_reg.prev_row,
                                         level_reg, 1'b1,
                                         level_reg, 1'b0,
                                         left_b_reg, flags_reg.left2);
            out_row_end   = 1'b0;
            out_frame_end = 1'b0;
        end else begin
            out_glyph     = filter_glyph(level_reg,
                                         ctr_a_reg, flags_reg.prev_row,
                                         level_reg, 1'b0,
                                         level_reg, 1'b0,
                                         ctr_b_reg, flags_reg.left1);
            out_row_end   = 1'b1;
            out_frame_end = 1'b1;
        end
        out_run_last = ((pend_reg & ~sel) == 3'b000);
    end

    assign out_free = !m_valid_reg || m_ready;
    assign out_load = (state_reg == ST_EMIT) && out_free;

    // sequencer
    always_comb begin
        state_next = state_reg;
        pend_next  = pend_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    pend_next  = {q_flags.has_c, q_flags.has_b, q_flags.has_a};
                    state_next = (pend_next == 3'b000) ? ST_IDLE : ST_RD0;
                end
            end
            ST_RD0:  state_next = ST_RD1;
            ST_RD1:  state_next = ST_RD2;
            ST_RD2:  state_next = ST_RD3;
            ST_RD3:  state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_load) begin
                    pend_next  = pend_reg & ~sel;
                    state_next = (pend_next == 3'b000) ? ST_IDLE : ST_EMIT;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pend_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // job and neighbor window
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            flags_reg <= q_flags;
            level_reg <= q_level;
            col_reg   <= q_col;
            slot_reg  <= q_slot;
        end
        if (state_reg == ST_RD1) begin
            up_a_reg  <= rd0_reg;
            ctr_a_reg <= rd1_reg;
        end
        if (state_reg == ST_RD2) begin
            right_a_reg <= rd0_reg;
            left_a_reg  <= rd1_reg;
        end
        if (state_reg == ST_RD3) begin
            ctr_b_reg  <= rd0_reg;
            left_b_reg <= rd1_reg;
        end
        if (out_load) begin
            m_glyph_reg     <= out_glyph;
            m_row_end_reg   <= out_row_end;
            m_frame_end_reg <= out_frame_end;
            m_run_last_reg  <= out_run_last;
        end
    end

    `IDPG_ASSERT_IMPLIES(a_emit_pending, aclk, aresetn, state_reg == ST_EMIT, pend_reg != 3'b000)
    `IDPG_ASSERT_NEXT(a_last_to_idle, aclk, aresetn, out_load && out_run_last, state_reg == ST_IDLE)

endmodule

`default_nettype wire

[src/isolated_pixel_despeckle_glyph_map.sv]
// Four-neighbor impulse-noise filter that turns a raster stream of pixel levels
// (0..9, higher values saturate to 9) into one ASCII glyph per pixel.
// Input channel s_*: one pixel_level per item, raster order, valid/ready.
// Output channel m_*: glyph, row_end, frame_end and run_last per item; run_last
// marks the last result caused by one input. Output runs one row behind input;
// on the last row of a frame the row is also flushed as it arrives, so one
// input causes zero to three results.
// Frame size comes from two APB registers: rows_in_use at 0x0, columns_in_use
// at 0x4; write them only while the block is idle.
// Sequencing: the back-end sequencer takes one input from the queue at a time
// and writes its level into the line store. For an input that causes results
// it then does three rounds of two line-store reads before filtering, loads
// the results into the output register oldest first, and takes the next input
// only after the last of them is loaded.
// A four-entry queue between classifier and sequencer keeps input flowing
// while results drain. When the receiver stalls, the output register holds
// its item, the sequencer waits, the queue fills and s_ready drops.
// Reset (aresetn low, synchronous) clears the counters, the queue, the output
// valid and restores 20 rows by 30 columns; the line store is not cleared.
`default_nettype none

module isolated_pixel_despeckle_glyph_map #(
    parameter int MAX_COLUMNS = 64
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [idpg_pkg::LEVEL_W-1:0]        s_pixel_level,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [idpg_pkg::GLYPH_W-1:0]             m_glyph,
    output logic                                     m_row_end,
    output logic                                     m_frame_end,
    output logic                                     m_run_last,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [2:0]                          paddr,
    input  wire logic [31:0]                         pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready
);
    import idpg_pkg::*;

    localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int FLAG_W = $bits(job_flags_t);
    localparam int JOB_W  = LEVEL_W + SLOT_W + COL_W + FLAG_W;

    logic [ROW_W-1:0]      rows_reg;
    logic [COLS_CFG_W-1:0] cols_reg;
    logic                  cfg_wr;

    logic               push, q_full, q_pop, q_valid;
    logic [LEVEL_W-1:0] f_level, b_level;
    logic [COL_W-1:0]   f_col, b_col;
    logic [SLOT_W-1:0]  f_slot, b_slot;
    job_flags_t         f_flags, b_flags;
    logic [JOB_W-1:0]   push_data, head_data;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= ROWS_RESET;
            cols_reg <= COLS_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_ROWS) begin
                rows_reg <= pwdata[ROW_W-1:0];
            end else begin
                cols_reg <= pwdata[COLS_CFG_W-1:0];
            end
        end
    end

    // register read back
    always_comb begin
        if (paddr[2] == REG_COLS) begin
            prdata = {{(32-COLS_CFG_W){1'b0}}, cols_reg};
        end else begin
            prdata = {{(32-ROW_W){1'b0}}, rows_reg};
        end
    end

    idpg_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .COL_W       (COL_W)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_level (s_pixel_level),
        .rows_cfg      (rows_reg),
        .cols_cfg      (cols_reg),
        .q_full        (q_full),
        .push          (push),
        .job_level     (f_level),
        .job_col       (f_col),
        .job_slot      (f_slot),
        .job_flags     (f_flags)
    );

    assign push_data = {f_level, f_slot, f_col, f_flags};

    idpg_queue #(
        .DATA_W (JOB_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .head_data (head_data),
        .not_empty (q_valid)
    );

    assign {b_level, b_slot, b_col, b_flags} = head_data;

    idpg_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .COL_W       (COL_W)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_level     (b_level),
        .q_col       (b_col),
        .q_slot      (b_slot),
        .q_flags     (b_flags),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_glyph     (m_glyph),
        .m_row_end   (m_row_end),
        .m_frame_end (m_frame_end),
        .m_run_last  (m_run_last)
    );

endmodule

`default_nettype wire
